// ----- rtl/core/jcp_pkg.sv -----
// jcp_pkg: shared constants and types for the junction cigar projector
// no dependencies; imported by jcp_step, jcp_out_stage, the top level and the checker

package jcp_pkg;

    localparam int DEF_POSITION_WIDTH = 32;
    localparam int DEF_RUN_WIDTH      = 24;
    localparam int DEF_READ_WIDTH     = 16;

    // per-run flags handed from the step logic to the result register
    typedef struct packed {
        logic is_skip;
        logic last;
        logic incomplete;
    } t_run_flags;

endpackage

// ----- rtl/core/jcp_in_stage.sv -----
// jcp_in_stage: input register of the projector, holds one accepted item
// standalone; feeds jcp_step

module jcp_in_stage #(
    parameter int POSITION_WIDTH = 32,
    parameter int RUN_WIDTH      = 24,
    parameter int READ_WIDTH     = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_op,
    input  logic [POSITION_WIDTH-1:0] i_base_position,
    input  logic [READ_WIDTH-1:0]     i_skip_offset,
    input  logic [READ_WIDTH-1:0]     i_read_length,
    input  logic [RUN_WIDTH-1:0]      i_segment_length,
    input  logic                      i_last_segment,
    input  logic                      i_take,
    output logic                      o_item_valid,
    output logic                      o_op,
    output logic [POSITION_WIDTH-1:0] o_base_position,
    output logic [READ_WIDTH-1:0]     o_skip_offset,
    output logic [READ_WIDTH-1:0]     o_read_length,
    output logic [RUN_WIDTH-1:0]      o_segment_length,
    output logic                      o_last_segment
);

    logic                      r_valid;
    logic                      r_op;
    logic [POSITION_WIDTH-1:0] r_base_position;
    logic [READ_WIDTH-1:0]     r_skip_offset;
    logic [READ_WIDTH-1:0]     r_read_length;
    logic [RUN_WIDTH-1:0]      r_segment_length;
    logic                      r_last_segment;
    logic                      load;

    // the held item leaves in the same cycle a new one arrives
    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_op             <= i_op;
            r_base_position  <= i_base_position;
            r_skip_offset    <= i_skip_offset;
            r_read_length    <= i_read_length;
            r_segment_length <= i_segment_length;
            r_last_segment   <= i_last_segment;
        end
    end

    assign o_item_valid     = r_valid;
    assign o_op             = r_op;
    assign o_base_position  = r_base_position;
    assign o_skip_offset    = r_skip_offset;
    assign o_read_length    = r_read_length;
    assign o_segment_length = r_segment_length;
    assign o_last_segment   = r_last_segment;

endmodule

// ----- rtl/core/jcp_step.sv -----
// jcp_step: read state and the per-item projection logic (skip offset, trim runs)
// depends on jcp_pkg; sits between jcp_in_stage and jcp_out_stage

module jcp_step #(
    parameter int POSITION_WIDTH = 32,
    parameter int RUN_WIDTH      = 24,
    parameter int READ_WIDTH     = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_item_valid,
    input  logic                      i_op,
    input  logic [POSITION_WIDTH-1:0] i_base_position,
    input  logic [READ_WIDTH-1:0]     i_skip_offset,
    input  logic [READ_WIDTH-1:0]     i_read_length,
    input  logic [RUN_WIDTH-1:0]      i_segment_length,
    input  logic                      i_last_segment,
    input  logic                      i_out_ready,
    output logic                      o_take,
    output logic                      o_res_valid,
    output logic [RUN_WIDTH-1:0]      o_res_length,
    output logic [POSITION_WIDTH-1:0] o_res_position,
    output jcp_pkg::t_run_flags       o_res_flags
);
    import jcp_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SKIP = 2'd1;
    localparam logic [1:0] PH_EMIT = 2'd2;

    localparam logic OP_HEADER = 1'b0;

    localparam int CW  = (RUN_WIDTH > READ_WIDTH) ? RUN_WIDTH : READ_WIDTH;
    localparam int SW  = ((POSITION_WIDTH > CW) ? POSITION_WIDTH : CW) + 1;

    logic [1:0]                r_phase,        n_phase;
    logic                      r_next_is_skip, n_next_is_skip;
    logic [READ_WIDTH-1:0]     r_offset_left,  n_offset_left;
    logic [READ_WIDTH-1:0]     r_read_left,    n_read_left;
    logic [POSITION_WIDTH-1:0] r_position,     n_position;

    logic [CW-1:0]             len_c;
    logic [CW-1:0]             off_c;
    logic [CW-1:0]             rl_c;
    logic [CW-1:0]             rem;
    logic [CW-1:0]             rl_after;
    logic [CW-1:0]             rl_less_len;
    logic [CW-1:0]             off_after;
    logic [SW-1:0]             sum_off;
    logic [SW-1:0]             sum_len;
    logic [POSITION_WIDTH-1:0] pos_off;
    logic [POSITION_WIDTH-1:0] pos_len;

    assign o_take = i_item_valid && i_out_ready;

    assign len_c       = CW'(i_segment_length);
    assign off_c       = CW'(r_offset_left);
    assign rl_c        = CW'(r_read_left);
    assign rem         = len_c - off_c;
    assign rl_after    = rl_c - rem;
    assign rl_less_len = rl_c - len_c;
    assign off_after   = off_c - len_c;

    // saturating position advance, by the offset or by the whole run
    assign sum_off = SW'(r_position) + SW'(r_offset_left);
    assign sum_len = SW'(r_position) + SW'(i_segment_length);
    assign pos_off = (|sum_off[SW-1:POSITION_WIDTH]) ? '1 : sum_off[POSITION_WIDTH-1:0];
    assign pos_len = (|sum_len[SW-1:POSITION_WIDTH]) ? '1 : sum_len[POSITION_WIDTH-1:0];

    always_comb begin
        n_phase        = r_phase;
        n_next_is_skip = r_next_is_skip;
        n_offset_left  = r_offset_left;
        n_read_left    = r_read_left;
        n_position     = r_position;
        o_res_valid    = 1'b0;
        o_res_length   = '0;
        o_res_position = r_position;
        o_res_flags    = '0;
        if (o_take) begin
            if (i_op == OP_HEADER) begin
                n_position     = i_base_position;
                n_offset_left  = i_skip_offset;
                n_read_left    = i_read_length;
                n_next_is_skip = 1'b0;
                n_phase        = PH_SKIP;
            end else begin
                case (r_phase)
                    PH_SKIP: begin
                        n_next_is_skip = ~r_next_is_skip;
                        o_res_flags.is_skip = 1'b0;
                        if (!r_next_is_skip && (len_c > off_c)) begin
                            // read starts inside this match
                            n_position     = pos_off;
                            n_offset_left  = '0;
                            o_res_position = pos_off;
                            o_res_valid    = 1'b1;
                            if (rem >= rl_c) begin
                                n_phase          = PH_IDLE;
                                o_res_length     = rl_c[RUN_WIDTH-1:0];
                                o_res_flags.last = 1'b1;
                            end else begin
                                n_read_left  = rl_after[READ_WIDTH-1:0];
                                o_res_length = rem[RUN_WIDTH-1:0];
                                if (i_last_segment) begin
                                    n_phase                = PH_IDLE;
                                    o_res_flags.last       = 1'b1;
                                    o_res_flags.incomplete = 1'b1;
                                end else begin
                                    n_phase = PH_EMIT;
                                end
                            end
                        end else begin
                            n_position = pos_len;
                            if (!r_next_is_skip) begin
                                n_offset_left = off_after[READ_WIDTH-1:0];
                            end
                            if (i_last_segment) begin
                                // junction ended before the offset was consumed
                                n_phase                = PH_IDLE;
                                o_res_valid            = 1'b1;
                                o_res_position         = pos_len;
                                o_res_flags.last       = 1'b1;
                                o_res_flags.incomplete = 1'b1;
                            end
                        end
                    end
                    PH_EMIT: begin
                        n_next_is_skip = ~r_next_is_skip;
                        o_res_valid    = 1'b1;
                        if (r_next_is_skip) begin
                            o_res_length        = i_segment_length;
                            o_res_flags.is_skip = 1'b1;
                            if (i_last_segment) begin
                                n_phase                = PH_IDLE;
                                o_res_flags.last       = 1'b1;
                                o_res_flags.incomplete = 1'b1;
                            end
                        end else if (len_c >= rl_c) begin
                            n_phase          = PH_IDLE;
                            o_res_length     = rl_c[RUN_WIDTH-1:0];
                            o_res_flags.last = 1'b1;
                        end else begin
                            n_read_left  = rl_less_len[READ_WIDTH-1:0];
                            o_res_length = i_segment_length;
                            if (i_last_segment) begin
                                n_phase                = PH_IDLE;
                                o_res_flags.last       = 1'b1;
                                o_res_flags.incomplete = 1'b1;
                            end
                        end
                    end
                    default: begin
                        // no read open: segment dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_next_is_skip <= 1'b0;
            r_offset_left  <= '0;
            r_read_left    <= '0;
            r_position     <= '0;
        end else begin
            r_phase        <= n_phase;
            r_next_is_skip <= n_next_is_skip;
            r_offset_left  <= n_offset_left;
            r_read_left    <= n_read_left;
            r_position     <= n_position;
        end
    end

endmodule

// ----- rtl/core/jcp_out_stage.sv -----
// jcp_out_stage: result register of the projector with the output handshake
// depends on jcp_pkg; fed by jcp_step

module jcp_out_stage #(
    parameter int POSITION_WIDTH = 32,
    parameter int RUN_WIDTH      = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_res_valid,
    input  logic [RUN_WIDTH-1:0]      i_res_length,
    input  logic [POSITION_WIDTH-1:0] i_res_position,
    input  jcp_pkg::t_run_flags       i_res_flags,
    output logic                      o_ready,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [RUN_WIDTH-1:0]      o_out_length,
    output logic                      o_out_is_skip,
    output logic [POSITION_WIDTH-1:0] o_read_position,
    output logic                      o_last_out,
    output logic                      o_incomplete
);
    import jcp_pkg::*;

    logic                      r_valid;
    logic [RUN_WIDTH-1:0]      r_length;
    logic [POSITION_WIDTH-1:0] r_position;
    t_run_flags                r_flags;

    // free, or emptied by a transfer this cycle
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res_valid) begin
            r_length   <= i_res_length;
            r_position <= i_res_position;
            r_flags    <= i_res_flags;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_length    = r_length;
    assign o_out_is_skip   = r_flags.is_skip;
    assign o_read_position = r_position;
    assign o_last_out      = r_flags.last;
    assign o_incomplete    = r_flags.incomplete;

endmodule

// ----- rtl/core/junction_cigar_projector.sv -----
// junction_cigar_projector: top level, projects junction-relative reads onto the genome
// depends on jcp_pkg, jcp_in_stage, jcp_step, jcp_out_stage
//
// Usage: the input channel (i_valid / o_stall) takes a header item (i_op = 0) that
// opens a read with its junction start, offset and length, followed by segment
// items (i_op = 1) giving the junction's alternating match / skip run lengths.
// The output channel (o_valid / i_stall) returns at most one run per segment:
// its length, match or skip, the read's genomic start, and last / incomplete flags.
// Headers give no result, nor do segments that arrive with no read open.
// An item is registered in the input register on entry and its result in the result
// register on exit, so a result is offered only after it has passed both registers.
// Throughput: one item per cycle while the output is not stalled, set by the
// combinational step logic between the two registers.
// A new item is taken while a result waits as long as the input register is free;
// when the receiver stalls, the result register holds, the input register fills
// and o_stall rises until the result is taken.
// Reset (synchronous, i_rst_n low) empties both registers and closes any open read.

module junction_cigar_projector #(
    parameter int POSITION_WIDTH = jcp_pkg::DEF_POSITION_WIDTH,
    parameter int RUN_WIDTH      = jcp_pkg::DEF_RUN_WIDTH,
    parameter int READ_WIDTH     = jcp_pkg::DEF_READ_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_op,
    input  logic [POSITION_WIDTH-1:0] i_base_position,
    input  logic [READ_WIDTH-1:0]     i_skip_offset,
    input  logic [READ_WIDTH-1:0]     i_read_length,
    input  logic [RUN_WIDTH-1:0]      i_segment_length,
    input  logic                      i_last_segment,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [RUN_WIDTH-1:0]      o_out_length,
    output logic                      o_out_is_skip,
    output logic [POSITION_WIDTH-1:0] o_read_position,
    output logic                      o_last_out,
    output logic                      o_incomplete
);
    import jcp_pkg::*;

    logic                      item_valid;
    logic                      item_op;
    logic [POSITION_WIDTH-1:0] item_base_position;
    logic [READ_WIDTH-1:0]     item_skip_offset;
    logic [READ_WIDTH-1:0]     item_read_length;
    logic [RUN_WIDTH-1:0]      item_segment_length;
    logic                      item_last_segment;
    logic                      take;
    logic                      out_ready;
    logic                      res_valid;
    logic [RUN_WIDTH-1:0]      res_length;
    logic [POSITION_WIDTH-1:0] res_position;
    t_run_flags                res_flags;

    jcp_in_stage #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .RUN_WIDTH      (RUN_WIDTH),
        .READ_WIDTH     (READ_WIDTH)
    ) u_in (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_base_position  (i_base_position),
        .i_skip_offset    (i_skip_offset),
        .i_read_length    (i_read_length),
        .i_segment_length (i_segment_length),
        .i_last_segment   (i_last_segment),
        .i_take           (take),
        .o_item_valid     (item_valid),
        .o_op             (item_op),
        .o_base_position  (item_base_position),
        .o_skip_offset    (item_skip_offset),
        .o_read_length    (item_read_length),
        .o_segment_length (item_segment_length),
        .o_last_segment   (item_last_segment)
    );

    jcp_step #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .RUN_WIDTH      (RUN_WIDTH),
        .READ_WIDTH     (READ_WIDTH)
    ) u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (item_valid),
        .i_op             (item_op),
        .i_base_position  (item_base_position),
        .i_skip_offset    (item_skip_offset),
        .i_read_length    (item_read_length),
        .i_segment_length (item_segment_length),
        .i_last_segment   (item_last_segment),
        .i_out_ready      (out_ready),
        .o_take           (take),
        .o_res_valid      (res_valid),
        .o_res_length     (res_length),
        .o_res_position   (res_position),
        .o_res_flags      (res_flags)
    );

    jcp_out_stage #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .RUN_WIDTH      (RUN_WIDTH)
    ) u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res_valid     (res_valid),
        .i_res_length    (res_length),
        .i_res_position  (res_position),
        .i_res_flags     (res_flags),
        .o_ready         (out_ready),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_length    (o_out_length),
        .o_out_is_skip   (o_out_is_skip),
        .o_read_position (o_read_position),
        .o_last_out      (o_last_out),
        .o_incomplete    (o_incomplete)
    );

endmodule

// ----- rtl/core/jcp_checker.sv -----
// jcp_checker: port-level assertions for the junction cigar projector
// depends on jcp_pkg; bound to junction_cigar_projector below

module jcp_checker #(
    parameter int POSITION_WIDTH = jcp_pkg::DEF_POSITION_WIDTH,
    parameter int RUN_WIDTH      = jcp_pkg::DEF_RUN_WIDTH
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [RUN_WIDTH-1:0]      o_out_length,
    input logic                      o_out_is_skip,
    input logic [POSITION_WIDTH-1:0] o_read_position,
    input logic                      o_last_out,
    input logic                      o_incomplete
);
    import jcp_pkg::*;

    // a stalled result stays offered with the same payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_length)
            && $stable(o_read_position) && $stable(o_out_is_skip)
            && $stable(o_last_out) && $stable(o_incomplete))
        else $error("stalled result changed");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // an incomplete read always closes with that run
    a_inc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_incomplete |-> o_last_out)
        else $error("incomplete flag on a non-final run");

    // a skip run closes a read only when the junction ran out
    a_skip_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_is_skip |-> (o_last_out == o_incomplete))
        else $error("skip run closed a covered read");

endmodule

bind junction_cigar_projector jcp_checker #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .RUN_WIDTH      (RUN_WIDTH)
) u_jcp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_out_length    (o_out_length),
    .o_out_is_skip   (o_out_is_skip),
    .o_read_position (o_read_position),
    .o_last_out      (o_last_out),
    .o_incomplete    (o_incomplete)
);

// ----- tb/testbench.sv -----
// testbench: self-checking bench for junction_cigar_projector, predicts each run from the
// item stream and compares transfers field by field under random gaps and stalls
// depends on jcp_pkg and the junction_cigar_projector rtl

module testbench;

    localparam int POS_W  = jcp_pkg::DEF_POSITION_WIDTH;
    localparam int RUN_W  = jcp_pkg::DEF_RUN_WIDTH;
    localparam int READ_W = jcp_pkg::DEF_READ_WIDTH;

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_SEGMENT = 1'b1;

    localparam int RANDOM_ITEMS = 1000;

    typedef enum logic [1:0] {
        CLOSED,
        SKIPPING,
        EMITTING
    } t_read_phase;

    typedef struct {
        logic              op;
        logic [POS_W-1:0]  base;
        logic [READ_W-1:0] offset;
        logic [READ_W-1:0] rlen;
        logic [RUN_W-1:0]  seglen;
        logic              last;
    } t_item;

    typedef struct {
        logic [RUN_W-1:0] length;
        logic             is_skip;
        logic [POS_W-1:0] position;
        logic             last;
        logic             incomplete;
    } t_run;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_valid          = 1'b0;
    logic              o_stall;
    logic              i_op             = OP_HEADER;
    logic [POS_W-1:0]  i_base_position  = '0;
    logic [READ_W-1:0] i_skip_offset    = '0;
    logic [READ_W-1:0] i_read_length    = '0;
    logic [RUN_W-1:0]  i_segment_length = '0;
    logic              i_last_segment   = 1'b0;
    logic              o_valid;
    logic              i_stall          = 1'b0;
    logic [RUN_W-1:0]  o_out_length;
    logic              o_out_is_skip;
    logic [POS_W-1:0]  o_read_position;
    logic              o_last_out;
    logic              o_incomplete;

    junction_cigar_projector dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_base_position  (i_base_position),
        .i_skip_offset    (i_skip_offset),
        .i_read_length    (i_read_length),
        .i_segment_length (i_segment_length),
        .i_last_segment   (i_last_segment),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_length     (o_out_length),
        .o_out_is_skip    (o_out_is_skip),
        .o_read_position  (o_read_position),
        .o_last_out       (o_last_out),
        .o_incomplete     (o_incomplete)
    );

    t_item item_queue[$];
    t_run  runs_due[$];
    t_item on_bus;
    int    mismatches = 0;

    // projection state mirrored from the block
    t_read_phase       phase       = CLOSED;
    logic              want_skip   = 1'b0;
    logic [READ_W-1:0] offset_left = '0;
    logic [READ_W-1:0] read_left   = '0;
    logic [POS_W-1:0]  genome_pos  = '0;

    int in_gap   = 0;
    int in_calm  = 0;
    int out_hold = 0;
    int out_free = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [POS_W-1:0] sat_add(logic [POS_W-1:0] a, logic [RUN_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + (POS_W+1)'(b);
        return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
    endfunction

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [RUN_W-1:0] pick_run();
        if ($urandom_range(0, 14) == 0) return RUN_W'($urandom());
        return RUN_W'($urandom_range(0, 25));
    endfunction

    task automatic push_header(logic [POS_W-1:0] base, logic [READ_W-1:0] offset,
                               logic [READ_W-1:0] rlen);
        t_item it;
        it.op     = OP_HEADER;
        it.base   = base;
        it.offset = offset;
        it.rlen   = rlen;
        it.seglen = RUN_W'($urandom());
        it.last   = 1'($urandom_range(0, 1));
        item_queue.insert(item_queue.size(), it);
    endtask

    task automatic push_segment(logic [RUN_W-1:0] seglen, logic last);
        t_item it;
        it.op     = OP_SEGMENT;
        it.base   = $urandom();
        it.offset = READ_W'($urandom());
        it.rlen   = READ_W'($urandom());
        it.seglen = seglen;
        it.last   = last;
        item_queue.insert(item_queue.size(), it);
    endtask

    // advances the projection by one accepted item and queues the run it yields
    task automatic project_item(t_item it);
        t_run             r;
        logic [RUN_W-1:0] rem;
        logic             this_skip;
        bit               emit;
        emit         = 0;
        r.length     = '0;
        r.is_skip    = 1'b0;
        r.last       = 1'b0;
        r.incomplete = 1'b0;
        if (it.op == OP_HEADER) begin
            genome_pos  = it.base;
            offset_left = it.offset;
            read_left   = it.rlen;
            want_skip   = 1'b0;
            phase       = SKIPPING;
            return;
        end
        if (phase == CLOSED) return;
        this_skip = want_skip;
        want_skip = ~want_skip;
        if (phase == SKIPPING) begin
            if (!this_skip && it.seglen > RUN_W'(offset_left)) begin
                genome_pos  = sat_add(genome_pos, RUN_W'(offset_left));
                rem         = it.seglen - RUN_W'(offset_left);
                offset_left = '0;
                emit        = 1;
                if (rem >= RUN_W'(read_left)) begin
                    phase    = CLOSED;
                    r.length = RUN_W'(read_left);
                    r.last   = 1'b1;
                end else begin
                    read_left = read_left - rem[READ_W-1:0];
                    r.length  = rem;
                    if (it.last) begin
                        phase        = CLOSED;
                        r.last       = 1'b1;
                        r.incomplete = 1'b1;
                    end else begin
                        phase = EMITTING;
                    end
                end
            end else begin
                genome_pos = sat_add(genome_pos, it.seglen);
                if (!this_skip) offset_left = offset_left - it.seglen[READ_W-1:0];
                if (it.last) begin
                    // junction ended before the offset was walked
                    phase        = CLOSED;
                    emit         = 1;
                    r.last       = 1'b1;
                    r.incomplete = 1'b1;
                end
            end
        end else if (this_skip) begin
            emit      = 1;
            r.length  = it.seglen;
            r.is_skip = 1'b1;
            if (it.last) begin
                phase        = CLOSED;
                r.last       = 1'b1;
                r.incomplete = 1'b1;
            end
        end else begin
            emit = 1;
            if (it.seglen >= RUN_W'(read_left)) begin
                phase    = CLOSED;
                r.length = RUN_W'(read_left);
                r.last   = 1'b1;
            end else begin
                read_left = read_left - it.seglen[READ_W-1:0];
                r.length  = it.seglen;
                if (it.last) begin
                    phase        = CLOSED;
                    r.last       = 1'b1;
                    r.incomplete = 1'b1;
                end
            end
        end
        if (emit) begin
            r.position = genome_pos;
            runs_due.insert(runs_due.size(), r);
        end
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // driver: one transfer per accepted item, gaps drawn per item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) project_item(on_bus);
            if (!i_valid || !o_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_valid <= 1'b0;
                end else if (item_queue.size() != 0) begin
                    on_bus = item_queue.pop_front();
                    i_op             <= on_bus.op;
                    i_base_position  <= on_bus.base;
                    i_skip_offset    <= on_bus.offset;
                    i_read_length    <= on_bus.rlen;
                    i_segment_length <= on_bus.seglen;
                    i_last_segment   <= on_bus.last;
                    i_valid          <= 1'b1;
                    if (in_calm > 0) begin
                        in_calm--;
                        in_gap = 0;
                    end else begin
                        in_gap = pick_gap();
                        if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(40, 150);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        t_run want;
        logic stall_next;
        stall_next = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (runs_due.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, %s %0h %0b %0h %0b %0b",
                             $time, "actual len skip pos last inc", o_out_length,
                             o_out_is_skip, o_read_position, o_last_out, o_incomplete);
                    mismatches++;
                end else begin
                    want = runs_due.pop_front();
                    check_field("out_length", want.length, o_out_length);
                    check_field("out_is_skip", want.is_skip, o_out_is_skip);
                    check_field("read_position", want.position, o_read_position);
                    check_field("last_out", want.last, o_last_out);
                    check_field("incomplete", want.incomplete, o_incomplete);
                end
            end
            if (out_hold > 0) begin
                out_hold--;
                stall_next = 1'b1;
            end else if (out_free > 0) begin
                out_free--;
            end else begin
                out_hold = pick_gap();
                out_free = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
                                                        : $urandom_range(0, 6);
                if (out_hold > 0) begin
                    out_hold--;
                    stall_next = 1'b1;
                end
            end
        end
        i_stall <= stall_next;
    end

    initial begin
        #20_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        int          nseg;
        int          target;
        logic [POS_W-1:0] base;
        logic [READ_W-1:0] offset;
        logic [READ_W-1:0] rlen;

        // segment with no read open is dropped
        push_segment(7, 1'b0);
        // zero read length gives a zero-length final match
        push_header(0, 0, 0);
        push_segment(5, 1'b0);
        // junction runs after the read is covered are dropped
        push_segment(9, 1'b1);
        // leading match exactly covering offset plus read
        push_header(100, 3, 10);
        push_segment(13, 1'b0);
        // open read abandoned by a new header
        push_header(600, 0, 9);
        push_segment(2, 1'b0);
        // extremes, position saturates while walking the offset
        push_header({POS_W{1'b1}} - 15, {READ_W{1'b1}}, {READ_W{1'b1}});
        push_segment(100, 1'b0);
        push_segment({RUN_W{1'b1}}, 1'b0);
        push_segment({RUN_W{1'b1}}, 1'b1);
        // junction ends while still skipping the offset
        push_header(200, 2, 50);
        push_segment(1, 1'b0);
        push_segment(7, 1'b0);
        push_segment(1, 1'b1);
        // junction ends on a skip run while emitting
        push_header(300, 0, 20);
        push_segment(5, 1'b0);
        push_segment(3, 1'b1);
        // junction ends on a match run while emitting
        push_header(400, 1, 20);
        push_segment(5, 1'b0);
        push_segment(2, 1'b0);
        push_segment(3, 1'b1);
        // junction ends on the first match past the offset
        push_header(500, 0, 30);
        push_segment(4, 1'b1);

        target = item_queue.size() + RANDOM_ITEMS;
        while (item_queue.size() < target) begin
            if ($urandom_range(0, 99) < 8) begin
                push_segment(RUN_W'($urandom()), 1'($urandom_range(0, 1)));
            end else begin
                base   = ($urandom_range(0, 9) == 0) ? {POS_W{1'b1}} - $urandom_range(0, 200)
                                                     : $urandom();
                offset = READ_W'(($urandom_range(0, 11) == 0) ? $urandom()
                                                              : $urandom_range(0, 40));
                rlen   = READ_W'(($urandom_range(0, 11) == 0) ? $urandom()
                                                              : $urandom_range(0, 60));
                push_header(base, offset, rlen);
                nseg = $urandom_range(1, 12);
                // occasionally the final run is unmarked, leaving the read open
                for (int k = 0; k < nseg; k++) begin
                    push_segment(pick_run(), (k == nseg - 1) && ($urandom_range(0, 9) != 0));
                end
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (item_queue.size() != 0 || i_valid || runs_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (runs_due.size() != 0) begin
            $display("%0t: %0d expected transfers never arrived", $time, runs_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
